// ===== design/cmta_pkg.sv =====
// ----------------------------------------------------------------------------
// cmta_pkg - shared types and constants of the cube map texel address unit
// Field widths, face and register codes, and the transfer payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cmta_pkg;

   // Width of one direction component (two's complement).
   localparam int CMTA_COMP_BITS    = 16;
   // Width of the face size registers.
   localparam int CMTA_REG_SIZE_BITS = 13;
   localparam int CMTA_COUNT_BITS   = 3;
   localparam int CMTA_FACE_BITS    = 3;
   localparam int CMTA_TEXEL_BITS   = 12;
   localparam int CMTA_INDEX_BITS   = 24;
   localparam int CMTA_CSR_IDX_BITS = 2;
   localparam int CMTA_CSR_DATA_BITS = CMTA_REG_SIZE_BITS;

   // Register indexes of the configuration port.
   localparam logic [CMTA_CSR_IDX_BITS-1:0] CMTA_CSR_FACE_WIDTH  = 2'd0;
   localparam logic [CMTA_CSR_IDX_BITS-1:0] CMTA_CSR_FACE_HEIGHT = 2'd1;
   localparam logic [CMTA_CSR_IDX_BITS-1:0] CMTA_CSR_FACE_COUNT  = 2'd2;

   // Register values after reset.
   localparam logic [CMTA_REG_SIZE_BITS-1:0] CMTA_RESET_WIDTH  = 13'd256;
   localparam logic [CMTA_REG_SIZE_BITS-1:0] CMTA_RESET_HEIGHT = 13'd256;
   localparam logic [CMTA_COUNT_BITS-1:0]    CMTA_RESET_COUNT  = 3'd6;
   // A face count of all ones leaves the face number unlimited.
   localparam logic [CMTA_COUNT_BITS-1:0]    CMTA_COUNT_UNLIMITED = 3'd7;

   // Face codes.
   localparam logic [CMTA_FACE_BITS-1:0] CMTA_FACE_POS_X = 3'd0;
   localparam logic [CMTA_FACE_BITS-1:0] CMTA_FACE_NEG_X = 3'd1;
   localparam logic [CMTA_FACE_BITS-1:0] CMTA_FACE_POS_Y = 3'd2;
   localparam logic [CMTA_FACE_BITS-1:0] CMTA_FACE_NEG_Y = 3'd3;
   localparam logic [CMTA_FACE_BITS-1:0] CMTA_FACE_POS_Z = 3'd4;
   localparam logic [CMTA_FACE_BITS-1:0] CMTA_FACE_NEG_Z = 3'd5;

   typedef struct packed {
      logic signed [CMTA_COMP_BITS-1:0] dir_x;
      logic signed [CMTA_COMP_BITS-1:0] dir_y;
      logic signed [CMTA_COMP_BITS-1:0] dir_z;
   } cmta_req_type;

   typedef struct packed {
      logic                       hit_valid;
      logic [CMTA_FACE_BITS-1:0]  face_index;
      logic [CMTA_TEXEL_BITS-1:0] texel_x;
      logic [CMTA_TEXEL_BITS-1:0] texel_y;
      logic [CMTA_INDEX_BITS-1:0] texel_index;
   } cmta_rsp_type;

   // Sideband that rides along the pipeline with each lookup.
   typedef struct packed {
      logic                      hit;
      logic [CMTA_FACE_BITS-1:0] face;
   } cmta_tag_type;

endpackage

`default_nettype wire

// ===== design/cmta_face_select.sv =====
// ----------------------------------------------------------------------------
// cmta_face_select - major axis pick and face coordinate forming
// Picks the face, forms sc+ma, tc+ma and ma, and limits the face number.
// ----------------------------------------------------------------------------
`default_nettype none

module cmta_face_select (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       in_valid,
   output logic                                      in_ready,
   input  wire cmta_pkg::cmta_req_type               in_dir,
   input  wire [cmta_pkg::CMTA_COUNT_BITS-1:0]       face_count,
   output logic                                      out_valid,
   input  wire                                       out_ready,
   output cmta_pkg::cmta_tag_type                    out_tag,
   output logic [cmta_pkg::CMTA_COMP_BITS-1:0]       out_ma,
   output logic [cmta_pkg::CMTA_COMP_BITS:0]         out_base_x,
   output logic [cmta_pkg::CMTA_COMP_BITS:0]         out_base_y
);

   localparam int CB = cmta_pkg::CMTA_COMP_BITS;

   logic                   valid_ff, valid_in;
   cmta_pkg::cmta_tag_type tag_ff, tag_in;
   logic [CB-1:0]          ma_ff, ma_in;
   logic [CB:0]            base_x_ff, base_x_in, base_y_ff, base_y_in;

   logic signed [CB:0]   x_w, y_w, z_w, nx, ny, nz, sc, tc;
   logic [CB-1:0]        ax, ay, az;
   logic signed [CB+1:0] sum_x, sum_y;
   logic [cmta_pkg::CMTA_FACE_BITS-1:0]  face;
   logic [cmta_pkg::CMTA_COUNT_BITS-1:0] count_m1;
   logic                                 nonzero;

   always_comb begin
      x_w = {in_dir.dir_x[CB-1], in_dir.dir_x};
      y_w = {in_dir.dir_y[CB-1], in_dir.dir_y};
      z_w = {in_dir.dir_z[CB-1], in_dir.dir_z};
      nx  = -x_w;
      ny  = -y_w;
      nz  = -z_w;
      ax  = in_dir.dir_x[CB-1] ? nx[CB-1:0] : x_w[CB-1:0];
      ay  = in_dir.dir_y[CB-1] ? ny[CB-1:0] : y_w[CB-1:0];
      az  = in_dir.dir_z[CB-1] ? nz[CB-1:0] : z_w[CB-1:0];

      // Ties favor X, then Y.
      if (ax >= ay && ax >= az) begin
         ma_in = ax;
         face  = in_dir.dir_x[CB-1] ? cmta_pkg::CMTA_FACE_NEG_X : cmta_pkg::CMTA_FACE_POS_X;
         sc    = in_dir.dir_x[CB-1] ? z_w : nz;
         tc    = ny;
      end else if (ay >= az) begin
         ma_in = ay;
         face  = in_dir.dir_y[CB-1] ? cmta_pkg::CMTA_FACE_NEG_Y : cmta_pkg::CMTA_FACE_POS_Y;
         sc    = x_w;
         tc    = in_dir.dir_y[CB-1] ? nz : z_w;
      end else begin
         ma_in = az;
         face  = in_dir.dir_z[CB-1] ? cmta_pkg::CMTA_FACE_NEG_Z : cmta_pkg::CMTA_FACE_POS_Z;
         sc    = in_dir.dir_z[CB-1] ? nx : x_w;
         tc    = ny;
      end

      // Shift face coordinates into [0, 2*ma].
      sum_x     = {sc[CB], sc} + {2'b00, ma_in};
      sum_y     = {tc[CB], tc} + {2'b00, ma_in};
      base_x_in = sum_x[CB:0];
      base_y_in = sum_y[CB:0];

      nonzero  = (ax != '0) || (ay != '0) || (az != '0);
      count_m1 = face_count - 3'd1;
      tag_in.hit = nonzero && (face_count != '0);
      if (face_count != cmta_pkg::CMTA_COUNT_UNLIMITED && face > count_m1) begin
         tag_in.face = count_m1;
      end else begin
         tag_in.face = face;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tag_ff    <= tag_in;
         ma_ff     <= ma_in;
         base_x_ff <= base_x_in;
         base_y_ff <= base_y_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_tag    = tag_ff;
   assign out_ma     = ma_ff;
   assign out_base_x = base_x_ff;
   assign out_base_y = base_y_ff;

endmodule

`default_nettype wire

// ===== design/cmta_scale.sv =====
// ----------------------------------------------------------------------------
// cmta_scale - numerator and divisor forming
// Multiplies the shifted face coordinates by size-1 and doubles ma.
// ----------------------------------------------------------------------------
`default_nettype none

module cmta_scale #(
   parameter int SIZE_BITS = 13
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   in_valid,
   output logic                                  in_ready,
   input  wire cmta_pkg::cmta_tag_type           in_tag,
   input  wire [cmta_pkg::CMTA_COMP_BITS-1:0]    in_ma,
   input  wire [cmta_pkg::CMTA_COMP_BITS:0]      in_base_x,
   input  wire [cmta_pkg::CMTA_COMP_BITS:0]      in_base_y,
   input  wire [SIZE_BITS-1:0]                   width_m1,
   input  wire [SIZE_BITS-1:0]                   height_m1,
   output logic                                  out_valid,
   input  wire                                   out_ready,
   output cmta_pkg::cmta_tag_type                out_tag,
   output logic [cmta_pkg::CMTA_COMP_BITS+SIZE_BITS:0] out_num_x,
   output logic [cmta_pkg::CMTA_COMP_BITS+SIZE_BITS:0] out_num_y,
   output logic [cmta_pkg::CMTA_COMP_BITS:0]           out_den
);

   localparam int CB       = cmta_pkg::CMTA_COMP_BITS;
   localparam int NUM_BITS = CB + 1 + SIZE_BITS;

   logic                   valid_ff, valid_in;
   cmta_pkg::cmta_tag_type tag_ff;
   logic [NUM_BITS-1:0]    num_x_ff, num_x_in, num_y_ff, num_y_in;
   logic [CB:0]            den_ff, den_in;

   always_comb begin
      num_x_in = NUM_BITS'(in_base_x) * NUM_BITS'(width_m1);
      num_y_in = NUM_BITS'(in_base_y) * NUM_BITS'(height_m1);
      den_in   = {in_ma, 1'b0};
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tag_ff   <= in_tag;
         num_x_ff <= num_x_in;
         num_y_ff <= num_y_in;
         den_ff   <= den_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_num_x = num_x_ff;
   assign out_num_y = num_y_ff;
   assign out_den   = den_ff;

endmodule

`default_nettype wire

// ===== design/cmta_div_cell.sv =====
// ----------------------------------------------------------------------------
// cmta_div_cell - one restoring division step for both texel axes
// Decides quotient bit STEP of x and y and hands the remainders on.
// ----------------------------------------------------------------------------
`default_nettype none

module cmta_div_cell #(
   parameter int SIZE_BITS = 13,
   parameter int STEP      = 0
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   in_valid,
   output logic                                  in_ready,
   input  wire cmta_pkg::cmta_tag_type           in_tag,
   input  wire [cmta_pkg::CMTA_COMP_BITS+SIZE_BITS:0] in_rem_x,
   input  wire [cmta_pkg::CMTA_COMP_BITS+SIZE_BITS:0] in_rem_y,
   input  wire [SIZE_BITS-1:0]                   in_q_x,
   input  wire [SIZE_BITS-1:0]                   in_q_y,
   input  wire [cmta_pkg::CMTA_COMP_BITS:0]      in_den,
   output logic                                  out_valid,
   input  wire                                   out_ready,
   output cmta_pkg::cmta_tag_type                out_tag,
   output logic [cmta_pkg::CMTA_COMP_BITS+SIZE_BITS:0] out_rem_x,
   output logic [cmta_pkg::CMTA_COMP_BITS+SIZE_BITS:0] out_rem_y,
   output logic [SIZE_BITS-1:0]                  out_q_x,
   output logic [SIZE_BITS-1:0]                  out_q_y,
   output logic [cmta_pkg::CMTA_COMP_BITS:0]     out_den
);

   localparam int CB       = cmta_pkg::CMTA_COMP_BITS;
   localparam int NUM_BITS = CB + 1 + SIZE_BITS;

   logic                   valid_ff, valid_in;
   cmta_pkg::cmta_tag_type tag_ff;
   logic [NUM_BITS-1:0]    rem_x_ff, rem_x_in, rem_y_ff, rem_y_in, shifted;
   logic [SIZE_BITS-1:0]   q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic [CB:0]            den_ff;

   always_comb begin
      // The quotient never exceeds size-1; the shifted divisor fits in NUM_BITS.
      shifted  = NUM_BITS'(in_den) << STEP;
      rem_x_in = in_rem_x;
      rem_y_in = in_rem_y;
      q_x_in   = in_q_x;
      q_y_in   = in_q_y;
      if (in_rem_x >= shifted) begin
         rem_x_in     = in_rem_x - shifted;
         q_x_in[STEP] = 1'b1;
      end
      if (in_rem_y >= shifted) begin
         rem_y_in     = in_rem_y - shifted;
         q_y_in[STEP] = 1'b1;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tag_ff   <= in_tag;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         den_ff   <= in_den;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_q_x   = q_x_ff;
   assign out_q_y   = q_y_ff;
   assign out_den   = den_ff;

endmodule

`default_nettype wire

// ===== design/cmta_index.sv =====
// ----------------------------------------------------------------------------
// cmta_index - texel clamp, linear index and result register
// Clamps the quotients, forms y*width+x and holds the result for transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module cmta_index #(
   parameter int SIZE_BITS = 13
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire cmta_pkg::cmta_tag_type  in_tag,
   input  wire [SIZE_BITS-1:0]          in_q_x,
   input  wire [SIZE_BITS-1:0]          in_q_y,
   input  wire [SIZE_BITS-1:0]          width,
   input  wire [SIZE_BITS-1:0]          width_m1,
   input  wire [SIZE_BITS-1:0]          height_m1,
   output logic                         out_valid,
   input  wire                          out_ready,
   output cmta_pkg::cmta_rsp_type       out_rsp
);

   localparam int PROD_BITS = 2 * SIZE_BITS + 1;

   logic                   valid_ff, valid_in;
   cmta_pkg::cmta_rsp_type rsp_ff, rsp_in;
   logic [SIZE_BITS-1:0]   tx, ty;
   logic [PROD_BITS-1:0]   linear;

   always_comb begin
      tx     = (in_q_x > width_m1) ? width_m1 : in_q_x;
      ty     = (in_q_y > height_m1) ? height_m1 : in_q_y;
      linear = PROD_BITS'(ty) * PROD_BITS'(width) + PROD_BITS'(tx);
      rsp_in = '0;
      // Background lookups leave every field zero.
      if (in_tag.hit) begin
         rsp_in.hit_valid   = 1'b1;
         rsp_in.face_index  = in_tag.face;
         rsp_in.texel_x     = cmta_pkg::CMTA_TEXEL_BITS'(tx);
         rsp_in.texel_y     = cmta_pkg::CMTA_TEXEL_BITS'(ty);
         rsp_in.texel_index = cmta_pkg::CMTA_INDEX_BITS'(linear);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

// ===== design/cube_map_texel_address_unit.sv =====
// ----------------------------------------------------------------------------
// cube_map_texel_address_unit - cube map face and texel address
// Maps a lookup direction to a face number, texel column, row and linear index.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   req     | in        | req_valid / req_ready  | cmta_req_type (dir_x,y,z)
//   rsp     | out       | rsp_valid / rsp_ready  | cmta_rsp_type (hit, face, texel)
//   csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// One direction enters per cycle while req_ready is high. The stages are face
// select, scale multiply, one restoring division cell per quotient bit, then the
// index register, which is also the result register.
// Each stage holds its transfer only while the stage after it is full and
// stalled, so bubbles close up; a stalled result stops new input only once all
// SIZE_BITS + 3 stages hold a transfer.
// Reset clears the stage valid bits and loads 256 x 256 faces, six of them.
// The csr port is always ready; write it only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_map_texel_address_unit #(
   parameter int MAX_FACE_SIZE = 4096
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_ready,
   input  wire cmta_pkg::cmta_req_type                 req_payload,
   output logic                                        rsp_valid,
   input  wire                                         rsp_ready,
   output cmta_pkg::cmta_rsp_type                      rsp_payload,
   input  wire                                         csr_valid,
   output logic                                        csr_ready,
   input  wire [cmta_pkg::CMTA_CSR_IDX_BITS-1:0]       csr_index,
   input  wire [cmta_pkg::CMTA_CSR_DATA_BITS-1:0]      csr_data
);

   // Effective face size never exceeds MAX_FACE_SIZE, nor the size register unless that is zero.
   localparam int MAX_SIZE_BITS = $clog2(MAX_FACE_SIZE + 1);
   localparam int SIZE_BITS     = (MAX_SIZE_BITS < cmta_pkg::CMTA_REG_SIZE_BITS)
                                  ? MAX_SIZE_BITS : cmta_pkg::CMTA_REG_SIZE_BITS;
   localparam int CB            = cmta_pkg::CMTA_COMP_BITS;
   localparam int NUM_BITS      = CB + 1 + SIZE_BITS;
   localparam int RB            = cmta_pkg::CMTA_REG_SIZE_BITS;

   // ---- configuration registers -------------------------------------------
   logic [RB-1:0]                        width_ff, height_ff;
   logic [cmta_pkg::CMTA_COUNT_BITS-1:0] count_ff;
   logic [SIZE_BITS-1:0]                 eff_width, eff_height, width_m1, height_m1;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cmta_pkg::CMTA_RESET_WIDTH;
         height_ff <= cmta_pkg::CMTA_RESET_HEIGHT;
         count_ff  <= cmta_pkg::CMTA_RESET_COUNT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cmta_pkg::CMTA_CSR_FACE_WIDTH: begin
               width_ff <= csr_data;
            end
            cmta_pkg::CMTA_CSR_FACE_HEIGHT: begin
               height_ff <= csr_data;
            end
            cmta_pkg::CMTA_CSR_FACE_COUNT: begin
               count_ff <= cmta_pkg::CMTA_COUNT_BITS'(csr_data);
            end
            default: begin
               // Drop writes to unmapped indexes.
            end
         endcase
      end
   end

   // Treat size zero as one and cap sizes at MAX_FACE_SIZE.
   always_comb begin
      if (width_ff == '0) begin
         eff_width = SIZE_BITS'(1);
      end else if (32'(width_ff) > MAX_FACE_SIZE) begin
         eff_width = SIZE_BITS'(MAX_FACE_SIZE);
      end else begin
         eff_width = SIZE_BITS'(width_ff);
      end
      if (height_ff == '0) begin
         eff_height = SIZE_BITS'(1);
      end else if (32'(height_ff) > MAX_FACE_SIZE) begin
         eff_height = SIZE_BITS'(MAX_FACE_SIZE);
      end else begin
         eff_height = SIZE_BITS'(height_ff);
      end
      width_m1  = eff_width - SIZE_BITS'(1);
      height_m1 = eff_height - SIZE_BITS'(1);
   end

   // ---- face select stage -----------------------------------------------
   logic                   fs_valid, fs_ready;
   cmta_pkg::cmta_tag_type fs_tag;
   logic [CB-1:0]          fs_ma;
   logic [CB:0]            fs_base_x, fs_base_y;

   cmta_face_select u_face_select (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_dir     (req_payload),
      .face_count (count_ff),
      .out_valid  (fs_valid),
      .out_ready  (fs_ready),
      .out_tag    (fs_tag),
      .out_ma     (fs_ma),
      .out_base_x (fs_base_x),
      .out_base_y (fs_base_y)
   );

   // ---- scale stage -----------------------------------------------------
   // Chain index 0 is the scale stage output; index k+1 is cell k's output.
   logic                   ch_valid [SIZE_BITS+1];
   logic                   ch_ready [SIZE_BITS+1];
   cmta_pkg::cmta_tag_type ch_tag   [SIZE_BITS+1];
   logic [NUM_BITS-1:0]    ch_rem_x [SIZE_BITS+1];
   logic [NUM_BITS-1:0]    ch_rem_y [SIZE_BITS+1];
   logic [SIZE_BITS-1:0]   ch_q_x   [SIZE_BITS+1];
   logic [SIZE_BITS-1:0]   ch_q_y   [SIZE_BITS+1];
   logic [CB:0]            ch_den   [SIZE_BITS+1];

   cmta_scale #(
      .SIZE_BITS (SIZE_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fs_valid),
      .in_ready  (fs_ready),
      .in_tag    (fs_tag),
      .in_ma     (fs_ma),
      .in_base_x (fs_base_x),
      .in_base_y (fs_base_y),
      .width_m1  (width_m1),
      .height_m1 (height_m1),
      .out_valid (ch_valid[0]),
      .out_ready (ch_ready[0]),
      .out_tag   (ch_tag[0]),
      .out_num_x (ch_rem_x[0]),
      .out_num_y (ch_rem_y[0]),
      .out_den   (ch_den[0])
   );

   // Quotients start empty and fill one bit per cell, most significant first.
   assign ch_q_x[0] = '0;
   assign ch_q_y[0] = '0;

   // ---- division chain --------------------------------------------------
   for (genvar k = 0; k < SIZE_BITS; k++) begin : g_div
      cmta_div_cell #(
         .SIZE_BITS (SIZE_BITS),
         .STEP      (SIZE_BITS - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_valid[k]),
         .in_ready  (ch_ready[k]),
         .in_tag    (ch_tag[k]),
         .in_rem_x  (ch_rem_x[k]),
         .in_rem_y  (ch_rem_y[k]),
         .in_q_x    (ch_q_x[k]),
         .in_q_y    (ch_q_y[k]),
         .in_den    (ch_den[k]),
         .out_valid (ch_valid[k+1]),
         .out_ready (ch_ready[k+1]),
         .out_tag   (ch_tag[k+1]),
         .out_rem_x (ch_rem_x[k+1]),
         .out_rem_y (ch_rem_y[k+1]),
         .out_q_x   (ch_q_x[k+1]),
         .out_q_y   (ch_q_y[k+1]),
         .out_den   (ch_den[k+1])
      );
   end

   // ---- index and result stage -------------------------------------------
   cmta_index #(
      .SIZE_BITS (SIZE_BITS)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ch_valid[SIZE_BITS]),
      .in_ready  (ch_ready[SIZE_BITS]),
      .in_tag    (ch_tag[SIZE_BITS]),
      .in_q_x    (ch_q_x[SIZE_BITS]),
      .in_q_y    (ch_q_y[SIZE_BITS]),
      .width     (eff_width),
      .width_m1  (width_m1),
      .height_m1 (height_m1),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== verif/cmta_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cmta_checker - in-order scoreboard for the cube map texel address unit
// Tracks the register writes, predicts the result of every accepted lookup
// and compares each result transfer field by field with the oldest one.
// ----------------------------------------------------------------------------

module cmta_checker (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   input  wire                                     req_ready,
   input  wire cmta_pkg::cmta_req_type             req_payload,
   input  wire                                     rsp_valid,
   input  wire                                     rsp_ready,
   input  wire cmta_pkg::cmta_rsp_type             rsp_payload,
   input  wire                                     csr_valid,
   input  wire                                     csr_ready,
   input  wire [cmta_pkg::CMTA_CSR_IDX_BITS-1:0]   csr_index,
   input  wire [cmta_pkg::CMTA_CSR_DATA_BITS-1:0]  csr_data,
   output int                                      outstanding,
   output int                                      mismatches
);

   // Largest face edge the block resolves (its default size limit).
   localparam longint FACE_SIZE_CAP = 4096;

   logic [cmta_pkg::CMTA_REG_SIZE_BITS-1:0] width_reg;
   logic [cmta_pkg::CMTA_REG_SIZE_BITS-1:0] height_reg;
   logic [cmta_pkg::CMTA_COUNT_BITS-1:0]    count_reg;

   cmta_pkg::cmta_rsp_type expected_texels[$];

   task automatic compare_field(input string what, input longint got, input longint want);
      if (got != want) begin
         mismatches++;
         $display("%0t texel check: %s got %0d want %0d", $time, what, got, want);
      end
   endtask

   // A size of zero reads as one; anything past the cap reads as the cap.
   function automatic longint usable_size(input longint size);
      if (size < 1)
         return 1;
      if (size > FACE_SIZE_CAP)
         return FACE_SIZE_CAP;
      return size;
   endfunction

   function automatic longint texel_coord(input longint c, input longint major,
                                          input longint size);
      longint q;
      q = ((c + major) * (size - 1)) / (2 * major);
      if (q > size - 1)
         q = size - 1;
      return q;
   endfunction

   function automatic cmta_pkg::cmta_rsp_type predict_lookup(
      input cmta_pkg::cmta_req_type dir);
      longint x, y, z, ax, ay, az, major, s, t, w, h, col, row, lin;
      int face, faces;
      cmta_pkg::cmta_rsp_type r;
      r = '0;
      x = $signed(dir.dir_x);
      y = $signed(dir.dir_y);
      z = $signed(dir.dir_z);
      faces = count_reg;
      // Zero direction or no faces: background, all fields zero.
      if ((x == 0 && y == 0 && z == 0) || faces == 0)
         return r;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      // Ties favor X, then Y.
      if (ax >= ay && ax >= az) begin
         major = ax;
         face  = (x >= 0) ? cmta_pkg::CMTA_FACE_POS_X : cmta_pkg::CMTA_FACE_NEG_X;
         s     = (x >= 0) ? -z : z;
         t     = -y;
      end else if (ay >= az) begin
         major = ay;
         face  = (y >= 0) ? cmta_pkg::CMTA_FACE_POS_Y : cmta_pkg::CMTA_FACE_NEG_Y;
         s     = x;
         t     = (y >= 0) ? z : -z;
      end else begin
         major = az;
         face  = (z >= 0) ? cmta_pkg::CMTA_FACE_POS_Z : cmta_pkg::CMTA_FACE_NEG_Z;
         s     = (z >= 0) ? x : -x;
         t     = -y;
      end
      if (face > faces - 1)
         face = faces - 1;
      w   = usable_size(width_reg);
      h   = usable_size(height_reg);
      col = texel_coord(s, major, w);
      row = texel_coord(t, major, h);
      lin = row * w + col;
      r.hit_valid   = 1'b1;
      r.face_index  = face[cmta_pkg::CMTA_FACE_BITS-1:0];
      r.texel_x     = col[cmta_pkg::CMTA_TEXEL_BITS-1:0];
      r.texel_y     = row[cmta_pkg::CMTA_TEXEL_BITS-1:0];
      r.texel_index = lin[cmta_pkg::CMTA_INDEX_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : track
      cmta_pkg::cmta_rsp_type want;
      if (reset) begin
         width_reg  <= cmta_pkg::CMTA_RESET_WIDTH;
         height_reg <= cmta_pkg::CMTA_RESET_HEIGHT;
         count_reg  <= cmta_pkg::CMTA_RESET_COUNT;
         expected_texels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cmta_pkg::CMTA_CSR_FACE_WIDTH:  width_reg  <= csr_data;
               cmta_pkg::CMTA_CSR_FACE_HEIGHT: height_reg <= csr_data;
               cmta_pkg::CMTA_CSR_FACE_COUNT:
                  count_reg <= csr_data[cmta_pkg::CMTA_COUNT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_texels = {expected_texels, predict_lookup(req_payload)};
         if (rsp_valid && rsp_ready) begin
            if (expected_texels.size() == 0) begin
               compare_field("unexpected result, texel_index", rsp_payload.texel_index, -1);
            end else begin
               want = expected_texels.pop_front();
               compare_field("hit_valid",   rsp_payload.hit_valid,   want.hit_valid);
               compare_field("face_index",  rsp_payload.face_index,  want.face_index);
               compare_field("texel_x",     rsp_payload.texel_x,     want.texel_x);
               compare_field("texel_y",     rsp_payload.texel_y,     want.texel_y);
               compare_field("texel_index", rsp_payload.texel_index, want.texel_index);
            end
         end
      end
      outstanding <= expected_texels.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - cube map texel address unit
// Drives lookup directions and register writes into the unit, lets the
// checker predict and compare every result, and gives the verdict.
// ----------------------------------------------------------------------------

module testbench;

   // Cycles without any transfer before the run is declared hung.
   localparam int QUIET_LIMIT = 2000;

   logic                                     clock       = 1'b0;
   logic                                     reset       = 1'b1;
   logic                                     req_valid   = 1'b0;
   logic                                     req_ready;
   cmta_pkg::cmta_req_type                   req_payload = '0;
   logic                                     rsp_valid;
   logic                                     rsp_ready   = 1'b0;
   cmta_pkg::cmta_rsp_type                   rsp_payload;
   logic                                     csr_valid   = 1'b0;
   logic                                     csr_ready;
   logic [cmta_pkg::CMTA_CSR_IDX_BITS-1:0]   csr_index   = cmta_pkg::CMTA_CSR_FACE_WIDTH;
   logic [cmta_pkg::CMTA_CSR_DATA_BITS-1:0]  csr_data    = '0;

   int outstanding;
   int mismatches;
   int sent;
   int quiet = 0;

   cube_map_texel_address_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   cmta_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always #2 clock = ~clock;

   // Hold reset high at start-up, once.
   initial begin : reset_gen
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: any transfer on any channel resets the quiet count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Result side. Stall about a quarter of the cycles, except for a calm
   // window. After the 80th and the 330th result transfer, hold rsp_ready low
   // while the sender keeps offering: the pipeline fills and req_ready must drop.
   initial begin : rsp_drain
      int taken;
      int hold;
      taken = 0;
      hold  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            taken++;
            if (taken == 80 || taken == 330)
               hold = 80;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= (taken >= 200 && taken < 260) || ($urandom_range(0, 99) >= 24);
         end
      end
   end

   function automatic cmta_pkg::cmta_req_type aim(input int x, input int y, input int z);
      cmta_pkg::cmta_req_type d;
      d.dir_x = x[cmta_pkg::CMTA_COMP_BITS-1:0];
      d.dir_y = y[cmta_pkg::CMTA_COMP_BITS-1:0];
      d.dir_z = z[cmta_pkg::CMTA_COMP_BITS-1:0];
      return d;
   endfunction

   function automatic int flip(input int v);
      return $urandom_range(0, 1) ? v : -v;
   endfunction

   // Random direction: mostly raw bit patterns, plus shapes that land on the
   // interesting spots - axis ties, face edges, extremes, tiny vectors.
   function automatic cmta_pkg::cmta_req_type random_dir();
      int c[3];
      int m, axis, i;
      m    = $urandom_range(0, 32767);
      axis = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            for (i = 0; i < 3; i++) c[i] = $urandom_range(0, 65535);
         end
         4: begin
            for (i = 0; i < 3; i++) c[i] = $urandom_range(0, 8) - 4;
         end
         5: begin
            // magnitudes of m or below, often two or three of them equal
            for (i = 0; i < 3; i++) c[i] = flip($urandom_range(0, 1) ? m : $urandom_range(0, m));
         end
         6: begin
            for (i = 0; i < 3; i++) begin
               case ($urandom_range(0, 5))
                  0: c[i] = -32768;
                  1: c[i] = -32767;
                  2: c[i] = -1;
                  3: c[i] = 0;
                  4: c[i] = 1;
                  default: c[i] = 32767;
               endcase
            end
         end
         7: begin
            // one dominant axis, the others anywhere on the face
            for (i = 0; i < 3; i++) c[i] = flip($urandom_range(0, m));
            c[axis] = flip(m);
         end
         8: begin
            for (i = 0; i < 3; i++) c[i] = 0;
            c[axis] = $urandom_range(0, 65535);
         end
         default: begin
            // face corners and edges: minor axes at or just inside the major one
            for (i = 0; i < 3; i++) c[i] = flip((m > 0 && $urandom_range(0, 1)) ? m - 1 : m);
            c[axis] = flip(m);
         end
      endcase
      return aim(c[0], c[1], c[2]);
   endfunction

   // Offer one lookup, with an occasional idle cycle first; return at the
   // edge where it transfers. Valid stays high into the next item.
   task automatic send_dir(input cmta_pkg::cmta_req_type dir);
      while (!(sent >= 190 && sent < 270) && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= dir;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [cmta_pkg::CMTA_CSR_IDX_BITS-1:0] idx,
                            input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[cmta_pkg::CMTA_CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   initial begin : stimulus
      int phase, w, h, n;
      sent = 0;
      while (reset) @(posedge clock);
      for (phase = 0; phase < 10; phase++) begin
         if (phase == 0) begin
            // Reset setting: 256 x 256, six faces.
            send_dir(aim(0, 0, 0));                     // zero direction: background
            send_dir(aim(32767, 0, 0));
            send_dir(aim(-32768, 0, 0));
            send_dir(aim(0, 32767, 0));
            send_dir(aim(0, -32768, 0));
            send_dir(aim(0, 0, 32767));
            send_dir(aim(0, 0, -32768));
            send_dir(aim(8, 8, 8));                     // three-way tie goes to X, texel 0,0
            send_dir(aim(8, -8, -8));                   // +X far corner
            send_dir(aim(-8, 8, 8));
            send_dir(aim(3, 7, -7));                    // Y/Z tie goes to Y
            send_dir(aim(3, -7, 7));
            send_dir(aim(-32768, -32768, -32768));
            send_dir(aim(32767, -32768, 32767));
            send_dir(aim(-32768, 32767, 32767));
            send_dir(aim(1, -1, 0));
            send_dir(aim(0, 5, -5));
            send_dir(aim(-6, -6, 7));
            send_dir(aim(6, 6, -7));
            send_dir(aim(-1, 0, 0));
            send_dir(aim(100, -3, -100));               // X/Z tie goes to X
            send_dir(aim(0, -1, 0));
            send_dir(aim(0, 0, -1));
            send_dir(aim(-32767, 32767, -32767));
            send_dir(aim(12345, -23456, 30000));
         end else begin
            settle();
            case (phase)
               1: begin w = 1;    h = 1;    n = 1; end  // one-texel faces, one face
               2: begin w = 4096; h = 4096; n = cmta_pkg::CMTA_COUNT_UNLIMITED; end
               3: begin w = 0;    h = 8191; n = 0; end  // no faces: all background
               4: begin w = 8191; h = 0;    n = 3; end  // oversize and zero sizes
               5: begin w = 4097; h = 2;    n = 5; end
               6: begin w = 255;  h = 4095; n = 6; end
               default: begin
                  w = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(1, 64);
                  h = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(4090, 4100);
                  n = $urandom_range(0, 8191);      // upper bits of the count write are ignored
               end
            endcase
            write_reg(cmta_pkg::CMTA_CSR_FACE_WIDTH, w);
            write_reg(cmta_pkg::CMTA_CSR_FACE_HEIGHT, h);
            write_reg(cmta_pkg::CMTA_CSR_FACE_COUNT, n);
            csr_valid <= 1'b0;
         end
         repeat (50) send_dir(random_dir());
      end
      settle();
      // Give any stray result time to show up.
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
